### hw/rtl/psieve_pkg.sv
`timescale 1ns / 1ps

package psieve_pkg;

    localparam int MAX_BOUND    = 65536;
    localparam int BOUND_W      = $clog2(MAX_BOUND + 1);
    localparam int ADDR_W       = $clog2(MAX_BOUND);
    localparam int VALUE_W      = 16;
    localparam int P_W          = BOUND_W / 2 + 1;
    localparam int SQ_W         = BOUND_W + 1;
    localparam int IN_TDATA_W   = ((BOUND_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * BOUND_W + VALUE_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [BOUND_W-1:0] LOW_BOUND       = BOUND_W'(10);
    localparam logic [BOUND_W-1:0] FIRST_PRIME     = BOUND_W'(2);
    localparam logic [P_W-1:0]     FIRST_ODD_PRIME = P_W'(3);

    localparam logic MODE_SIEVE = 1'b0;
    localparam logic MODE_FETCH = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL,
        S_PRIME_RD,
        S_PRIME_CHK,
        S_MARK,
        S_COUNT,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_DONE
    } t_state;

endpackage

### hw/rtl/psieve_ram.sv
`timescale 1ns / 1ps

module psieve_ram #(
    parameter int W = 1,
    parameter int D = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/prime_sieve_engine_core.sv
`timescale 1ns / 1ps
// Sieve of Eratosthenes engine with a one-bit-per-number map in a single RAM.
// Input words arrive on the s_axis channel: tuser is the mode (0 runs the
// sieve, 1 fetches the next prime) and tdata carries the requested bound,
// which is clamped to 10..65536. Every input word produces exactly one output
// word on the m_axis channel with the prime count, the index and value of the
// fetched prime, and the exhausted flag in tuser.
// A sieve run fills the map, checks each odd candidate up to the square root,
// clears every multiple of each odd prime found, starting at its square, and
// then counts the survivors; the single map RAM port pair sets the pace. A
// fetch scans the map from the position after the last fetched prime until
// the next prime is found or the bound is reached.
// Only one word is processed at a time; a new word is accepted as soon as
// the previous result sits in the output register, even while it waits.
// If the receiver stalls and the output register is still full when the next
// result is ready, the engine holds that result and accepts nothing more.
// After reset no sieve has run: a fetch reports exhausted with all zeros.
// The map contents are not cleared at reset; a sieve run writes every entry
// it later reads.

module prime_sieve_engine_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // Fields from bit 0: sieve_bound.
    input  logic [psieve_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // Fields from bit 0: mode.
    input  logic                                  i_s_axis_tuser,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // Fields from bit 0: prime_count, prime_index, prime_value.
    output logic [psieve_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // Fields from bit 0: exhausted.
    output logic                                  o_m_axis_tuser
);

    import psieve_pkg::*;

    t_state r_state, n_state;

    logic [BOUND_W-1:0] r_bound, n_bound;
    logic [BOUND_W-1:0] r_count, n_count;
    logic [BOUND_W-1:0] r_scan, n_scan;
    logic [BOUND_W-1:0] r_emit, n_emit;
    logic [BOUND_W-1:0] r_idx, n_idx;
    logic [BOUND_W-1:0] r_tally, n_tally;
    logic [P_W-1:0]     r_p, n_p;
    logic [SQ_W-1:0]    r_sq, n_sq;
    logic [SQ_W-1:0]    r_m, n_m;
    logic               r_cvld, n_cvld;
    logic [BOUND_W-1:0] r_res_index, n_res_index;
    logic [VALUE_W-1:0] r_res_value, n_res_value;
    logic               r_res_exh, n_res_exh;
    logic               r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;
    logic               r_out_user, n_out_user;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic              ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic              ram_rdata;

    logic               in_accept;
    logic               out_free;
    logic [BOUND_W-1:0] req_bound;
    logic [BOUND_W-1:0] clamp_bound;
    logic [SQ_W-1:0]    bound_ext;
    logic [SQ_W-1:0]    next_sq;
    logic               fill_last;

    psieve_ram #(
        .W (1),
        .D (MAX_BOUND)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign req_bound       = i_s_axis_tdata[BOUND_W-1:0];
    assign bound_ext       = SQ_W'(r_bound);
    assign next_sq         = r_sq + SQ_W'({r_p, 2'b00}) + SQ_W'(4);
    assign fill_last       = (r_idx + BOUND_W'(1)) >= r_bound;

    always_comb begin
        if (req_bound < LOW_BOUND) begin
            clamp_bound = LOW_BOUND;
        end else if (req_bound > BOUND_W'(MAX_BOUND)) begin
            clamp_bound = BOUND_W'(MAX_BOUND);
        end else begin
            clamp_bound = req_bound;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = (i_s_axis_tuser == MODE_FETCH) ? S_SCAN_RD : S_FILL;
                end
            end
            S_FILL: begin
                if (fill_last) begin
                    n_state = S_PRIME_RD;
                end
            end
            S_PRIME_RD: begin
                n_state = (r_sq > bound_ext) ? S_COUNT : S_PRIME_CHK;
            end
            S_PRIME_CHK: begin
                n_state = ram_rdata ? S_MARK : S_PRIME_RD;
            end
            S_MARK: begin
                if (r_m >= bound_ext) begin
                    n_state = S_PRIME_RD;
                end
            end
            S_COUNT: begin
                if (r_idx >= r_bound && !r_cvld) begin
                    n_state = S_DONE;
                end
            end
            S_SCAN_RD: begin
                n_state = (r_idx >= r_bound) ? S_DONE : S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                n_state = ram_rdata ? S_DONE : S_SCAN_RD;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_bound     = r_bound;
        n_count     = r_count;
        n_scan      = r_scan;
        n_emit      = r_emit;
        n_idx       = r_idx;
        n_tally     = r_tally;
        n_p         = r_p;
        n_sq        = r_sq;
        n_m         = r_m;
        n_cvld      = 1'b0;
        n_res_index = r_res_index;
        n_res_value = r_res_value;
        n_res_exh   = r_res_exh;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        ram_we      = 1'b0;
        ram_waddr   = r_idx[ADDR_W-1:0];
        ram_wdata   = 1'b0;
        ram_raddr   = r_idx[ADDR_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_s_axis_tuser == MODE_FETCH) begin
                        n_idx = r_scan;
                    end else begin
                        n_bound = clamp_bound;
                        n_idx   = FIRST_PRIME;
                    end
                end
            end
            S_FILL: begin
                ram_we    = 1'b1;
                ram_wdata = (r_idx == FIRST_PRIME) || r_idx[0];
                n_idx     = r_idx + BOUND_W'(1);
                if (fill_last) begin
                    n_p  = FIRST_ODD_PRIME;
                    n_sq = SQ_W'(FIRST_ODD_PRIME) * SQ_W'(FIRST_ODD_PRIME);
                end
            end
            S_PRIME_RD: begin
                ram_raddr = ADDR_W'(r_p);
                if (r_sq > bound_ext) begin
                    n_idx   = FIRST_PRIME;
                    n_tally = '0;
                end
            end
            S_PRIME_CHK: begin
                if (ram_rdata) begin
                    n_m = r_sq;
                end else begin
                    n_p  = r_p + P_W'(2);
                    n_sq = next_sq;
                end
            end
            S_MARK: begin
                ram_waddr = r_m[ADDR_W-1:0];
                if (r_m < bound_ext) begin
                    ram_we = 1'b1;
                    n_m    = r_m + SQ_W'(r_p);
                end else begin
                    n_p  = r_p + P_W'(2);
                    n_sq = next_sq;
                end
            end
            S_COUNT: begin
                if (r_idx < r_bound) begin
                    n_cvld = 1'b1;
                    n_idx  = r_idx + BOUND_W'(1);
                end
                if (r_cvld && ram_rdata) begin
                    n_tally = r_tally + BOUND_W'(1);
                end
                if (r_idx >= r_bound && !r_cvld) begin
                    n_count     = r_tally;
                    n_scan      = FIRST_PRIME;
                    n_emit      = '0;
                    n_res_index = '0;
                    n_res_value = '0;
                    n_res_exh   = 1'b0;
                end
            end
            S_SCAN_RD: begin
                if (r_idx >= r_bound) begin
                    n_res_index = '0;
                    n_res_value = '0;
                    n_res_exh   = 1'b1;
                    if (r_bound > r_scan) begin
                        n_scan = r_bound;
                    end
                end
            end
            S_SCAN_CHK: begin
                if (ram_rdata) begin
                    n_emit      = r_emit + BOUND_W'(1);
                    n_scan      = r_idx + BOUND_W'(1);
                    n_res_index = r_emit + BOUND_W'(1);
                    n_res_value = r_idx[VALUE_W-1:0];
                    n_res_exh   = 1'b0;
                end else begin
                    n_idx = r_idx + BOUND_W'(1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = OUT_TDATA_W'({r_res_value, r_res_index, r_count});
                    n_out_user  = r_res_exh;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bound     <= '0;
            r_count     <= '0;
            r_scan      <= FIRST_PRIME;
            r_emit      <= '0;
            r_cvld      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bound     <= n_bound;
            r_count     <= n_count;
            r_scan      <= n_scan;
            r_emit      <= n_emit;
            r_cvld      <= n_cvld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_tally     <= n_tally;
        r_p         <= n_p;
        r_sq        <= n_sq;
        r_m         <= n_m;
        r_res_index <= n_res_index;
        r_res_value <= n_res_value;
        r_res_exh   <= n_res_exh;
        r_out_data  <= n_out_data;
        r_out_user  <= n_out_user;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_FILL || r_state == S_MARK))
        else $error("map written outside fill or mark phase");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (BOUND_W'(ram_waddr) < r_bound))
        else $error("map write beyond active bound");

    a_scan_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan >= FIRST_PRIME)
        else $error("scan position below two");

    a_count_le_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_count <= r_bound))
        else $error("prime count exceeds bound");

    a_exh_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_user) |->
            (r_out_data[OUT_FIELDS_W-1:BOUND_W] == '0))
        else $error("exhausted word carries a prime");

endmodule
